FILE: rtl/core/crbpc_pkg.sv
// Shared types, codes and helper functions for the clipped-region black pixel counter.
package crbpc_pkg;

  localparam int CLIP_W = 17;
  localparam int COUNT_W = 25;
  localparam int CFG_W = 13;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_COUNT = 1'b1;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd4096;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLIP_A,
    ST_CLIP_B,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic wr;
    logic clip_a;
    logic clip_b;
    logic setup;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } sts_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

endpackage

FILE: rtl/core/crbpc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module crbpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/crbpc_ctrl.sv
// Controller state machine for the clipped-region black pixel counter.
module crbpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              opcode,
  input  crbpc_pkg::sts_t   sts,
  output crbpc_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  crbpc_pkg::state_t state;
  crbpc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crbpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      crbpc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (opcode == crbpc_pkg::OP_WRITE) ? crbpc_pkg::ST_WRITE
                                                        : crbpc_pkg::ST_CLIP_A;
        end
      end
      crbpc_pkg::ST_WRITE:  state_next = crbpc_pkg::ST_IDLE;
      crbpc_pkg::ST_CLIP_A: state_next = crbpc_pkg::ST_CLIP_B;
      crbpc_pkg::ST_CLIP_B: state_next = crbpc_pkg::ST_SETUP;
      crbpc_pkg::ST_SETUP: begin
        state_next = sts.empty ? crbpc_pkg::ST_DONE : crbpc_pkg::ST_SCAN;
      end
      crbpc_pkg::ST_SCAN: begin
        if (sts.last) begin
          state_next = crbpc_pkg::ST_DRAIN1;
        end
      end
      crbpc_pkg::ST_DRAIN1: state_next = crbpc_pkg::ST_DRAIN2;
      crbpc_pkg::ST_DRAIN2: state_next = crbpc_pkg::ST_DONE;
      crbpc_pkg::ST_DONE:   state_next = crbpc_pkg::ST_IDLE;
      default:              state_next = crbpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      crbpc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      crbpc_pkg::ST_WRITE:  cmd.wr = 1'b1;
      crbpc_pkg::ST_CLIP_A: cmd.clip_a = 1'b1;
      crbpc_pkg::ST_CLIP_B: cmd.clip_b = 1'b1;
      crbpc_pkg::ST_SETUP:  cmd.setup = 1'b1;
      crbpc_pkg::ST_SCAN:   cmd.issue = 1'b1;
      crbpc_pkg::ST_DONE:   done = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/crbpc_dp.sv
// Datapath: config registers, clipping, word scan over the image RAM, masked popcount.
module crbpc_dp #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  crbpc_pkg::cmd_t                   cmd,
  output crbpc_pkg::sts_t                   sts,
  input  logic [11:0]                       word_row,
  input  logic [6:0]                        word_column,
  input  logic [31:0]                       word_bits,
  input  logic signed [13:0]                rect_x,
  input  logic signed [13:0]                rect_y,
  input  logic signed [13:0]                rect_width,
  input  logic signed [13:0]                rect_height,
  input  logic                              cfg_valid,
  input  logic                              cfg_index,
  input  logic [crbpc_pkg::CFG_W-1:0]       cfg_data,
  output logic [crbpc_pkg::COUNT_W-1:0]     black_count
);

  localparam int WPR = (MAX_WIDTH + 31) / 32;
  localparam int DEPTH = MAX_HEIGHT * WPR;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = crbpc_pkg::CLIP_W;

  logic [crbpc_pkg::CFG_W-1:0] image_width;
  logic [crbpc_pkg::CFG_W-1:0] image_height;

  logic [11:0]          wrow;
  logic [6:0]           wcol;
  logic [31:0]          wbits;
  logic signed [SW-1:0] rx;
  logic signed [SW-1:0] ry;
  logic signed [SW-1:0] rw;
  logic signed [SW-1:0] rh;
  logic signed [SW-1:0] iw;
  logic signed [SW-1:0] ih;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] ylast;

  logic [4:0]    lo_off;
  logic [4:0]    hi_off;
  logic [CW-1:0] c0;
  logic [CW-1:0] c1;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [RW-1:0] row_last;
  logic [AW-1:0] row_base;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [31:0]   mask;
  logic [31:0]   mask1;
  logic          v1;
  logic          v2;
  logic [5:0]    pc;
  logic [crbpc_pkg::COUNT_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= crbpc_pkg::IMAGE_WIDTH_RESET;
      image_height <= crbpc_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        crbpc_pkg::REG_IMAGE_WIDTH:  image_width <= cfg_data;
        crbpc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign iw = (32'(image_width) > 32'(MAX_WIDTH)) ? SW'(MAX_WIDTH)
                                                  : $signed(SW'(image_width));
  assign ih = (32'(image_height) > 32'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT)
                                                    : $signed(SW'(image_height));
  assign hi    = rx + rw - SW'(1);
  assign ylast = ry + rh - SW'(1);

  // rectangle capture and clipping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wrow  <= word_row;
      wcol  <= word_column;
      wbits <= word_bits;
      rx    <= SW'(rect_x);
      ry    <= SW'(rect_y);
      rw    <= SW'(rect_width);
      rh    <= SW'(rect_height);
    end else if (cmd.clip_a) begin
      if (rx < 0) begin
        rw <= rw + rx;
        rx <= '0;
      end
      if (ry < 0) begin
        rh <= rh + ry;
        ry <= '0;
      end
    end else if (cmd.clip_b) begin
      if (rx + rw > iw) begin
        rw <= iw - rx;
      end
      if (ry + rh > ih) begin
        rh <= ih - ry;
      end
    end
  end

  assign sts.empty = (rw <= 0) || (rh <= 0);
  assign sts.last  = (col == c1) && (row == row_last);

  // write path
  assign we = cmd.wr && (32'(wrow) < 32'(MAX_HEIGHT)) && (32'(wcol) < 32'(WPR));
  assign waddr = AW'(AW'(wrow) * AW'(WPR)) + AW'(wcol);

  // scan address and edge masks
  assign raddr = row_base + AW'(col);

  always_comb begin
    mask = 32'hFFFF_FFFF;
    if (col == c0) begin
      mask = mask & (32'hFFFF_FFFF << lo_off);
    end
    if (col == c1) begin
      mask = mask & (32'hFFFF_FFFF >> (5'd31 - hi_off));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lo_off   <= rx[4:0];
      hi_off   <= hi[4:0];
      c0       <= rx[CW+4:5];
      c1       <= hi[CW+4:5];
      col      <= rx[CW+4:5];
      row      <= ry[RW-1:0];
      row_last <= ylast[RW-1:0];
      row_base <= AW'(AW'(ry[RW-1:0]) * AW'(WPR));
    end else if (cmd.issue) begin
      if (col == c1) begin
        col      <= c0;
        row      <= row + RW'(1);
        row_base <= row_base + AW'(WPR);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mask1 <= mask;
    if (v1) begin
      pc <= crbpc_pkg::popcount32(rdata & mask1);
    end
    if (cmd.setup) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + crbpc_pkg::COUNT_W'(pc);
    end
  end

  assign black_count = acc;

  crbpc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_image_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wbits),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: rtl/core/clipped_region_black_pixel_count_top.sv
// Top level of the clipped-region black pixel counter.
// Holds a 1-bit image of up to MAX_HEIGHT rows of ceil(MAX_WIDTH/32) words
// in one RAM and counts set pixels inside a clipped rectangle. A command is
// taken when start is high and busy low. A word write keeps busy only in the
// cycle after the accepting edge and gives no result. A count clips the
// rectangle, scans each image word the clipped rectangle touches (rows
// times word columns) and presents black_count with done for exactly one
// cycle at its end; an empty clipped area skips the scan. The single RAM
// read port, one word per cycle, sets the scan time. The receiver cannot
// stall, so the result must be captured in the done cycle. Configuration
// writes are always ready and must only be made while idle.
module clipped_region_black_pixel_count_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [11:0]                   word_row,
  input  logic [6:0]                    word_column,
  input  logic [31:0]                   word_bits,
  input  logic signed [13:0]            rect_x,
  input  logic signed [13:0]            rect_y,
  input  logic signed [13:0]            rect_width,
  input  logic signed [13:0]            rect_height,
  output logic                          done,
  output logic [crbpc_pkg::COUNT_W-1:0] black_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [crbpc_pkg::CFG_W-1:0]   cfg_data
);

  crbpc_pkg::cmd_t cmd;
  crbpc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  crbpc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  crbpc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .word_row    (word_row),
    .word_column (word_column),
    .word_bits   (word_bits),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .black_count (black_count)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block not idle after result beat");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a start");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without a command in flight");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the clipped-region black pixel counter: word loads, counts, sizes.
module tb;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int WORDS_PER_ROW = MAX_W / 32;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic              op;
    logic [11:0]       row;
    logic [6:0]        col;
    logic [31:0]       bits;
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [13:0] w;
    logic signed [13:0] h;
  } pixel_cmd_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               opcode;
  logic [11:0]        word_row;
  logic [6:0]         word_column;
  logic [31:0]        word_bits;
  logic signed [13:0] rect_x;
  logic signed [13:0] rect_y;
  logic signed [13:0] rect_width;
  logic signed [13:0] rect_height;
  logic               done;
  logic [crbpc_pkg::COUNT_W-1:0] black_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [crbpc_pkg::CFG_W-1:0]   cfg_data;

  bit [31:0]          image_words [MAX_H*WORDS_PER_ROW];
  bit                 word_loaded [MAX_H*WORDS_PER_ROW];
  logic [crbpc_pkg::CFG_W-1:0]   image_width_reg;
  logic [crbpc_pkg::CFG_W-1:0]   image_height_reg;
  logic [crbpc_pkg::COUNT_W-1:0] expected_black_counts [$];
  logic [crbpc_pkg::COUNT_W-1:0] want_count;
  int                 errors;
  int                 stall_cycles;
  bit                 idling_on;

  clipped_region_black_pixel_count_top #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .word_row(word_row),
    .word_column(word_column),
    .word_bits(word_bits),
    .rect_x(rect_x),
    .rect_y(rect_y),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .done(done),
    .black_count(black_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_width();
    return (image_width_reg > MAX_W) ? MAX_W : int'(image_width_reg);
  endfunction

  function automatic int eff_height();
    return (image_height_reg > MAX_H) ? MAX_H : int'(image_height_reg);
  endfunction

  function automatic bit clip_rect(input pixel_cmd_t cmd, output int x0, output int y0,
                                   output int cw, output int ch);
    x0 = int'(cmd.x);
    y0 = int'(cmd.y);
    cw = int'(cmd.w);
    ch = int'(cmd.h);
    if (y0 < 0) begin
      ch += y0;
      y0 = 0;
    end
    if (x0 < 0) begin
      cw += x0;
      x0 = 0;
    end
    if (x0 + cw > eff_width()) cw = eff_width() - x0;
    if (y0 + ch > eff_height()) ch = eff_height() - y0;
    return (cw > 0 && ch > 0);
  endfunction

  function automatic logic [crbpc_pkg::COUNT_W-1:0] black_pixels_in(input pixel_cmd_t cmd,
                                                                    output bit reads_unloaded);
    int          x0;
    int          y0;
    int          cw;
    int          ch;
    int          hi;
    int          addr;
    bit [31:0]   mask;
    int unsigned total;
    total = 0;
    reads_unloaded = 1'b0;
    if (clip_rect(cmd, x0, y0, cw, ch)) begin
      hi = x0 + cw - 1;
      for (int r = y0; r < y0 + ch; r++) begin
        for (int c = x0 >>> 5; c <= hi >>> 5; c++) begin
          mask = '1;
          if (x0 > c * 32) mask &= 32'hFFFF_FFFF << (x0 - c * 32);
          if (hi < c * 32 + 31) mask &= 32'hFFFF_FFFF >> (31 - (hi - c * 32));
          addr = r * WORDS_PER_ROW + c;
          if (!word_loaded[addr]) reads_unloaded = 1'b1;
          total += $countones(image_words[addr] & mask);
        end
      end
    end
    return total[crbpc_pkg::COUNT_W-1:0];
  endfunction

  function automatic pixel_cmd_t word_cmd(input logic [11:0] row, input logic [6:0] col,
                                          input logic [31:0] bits);
    pixel_cmd_t cmd;
    cmd.op = crbpc_pkg::OP_WRITE;
    cmd.row = row;
    cmd.col = col;
    cmd.bits = bits;
    cmd.x = 14'($urandom);
    cmd.y = 14'($urandom);
    cmd.w = 14'($urandom);
    cmd.h = 14'($urandom);
    return cmd;
  endfunction

  function automatic pixel_cmd_t count_cmd(input int x, input int y, input int w, input int h);
    pixel_cmd_t cmd;
    cmd.op = crbpc_pkg::OP_COUNT;
    cmd.row = 12'($urandom);
    cmd.col = 7'($urandom);
    cmd.bits = $urandom;
    cmd.x = 14'(x);
    cmd.y = 14'(y);
    cmd.w = 14'(w);
    cmd.h = 14'(h);
    return cmd;
  endfunction

  function automatic pixel_cmd_t random_count();
    pixel_cmd_t cmd;
    bit         unloaded;
    int         iw;
    int         ih;
    iw = eff_width();
    ih = eff_height();
    case ($urandom_range(0, 9))
      0, 1: cmd = count_cmd($urandom, $urandom, $urandom, $urandom);
      2, 3: cmd = count_cmd($urandom_range(0, iw - 1), $urandom_range(0, ih - 1),
                            $urandom_range(1, 40), $urandom_range(1, 6));
      default: cmd = count_cmd(int'($urandom_range(0, iw + 48)) - 40,
                               int'($urandom_range(0, ih + 12)) - 8,
                               int'($urandom_range(0, iw + 44)) - 4,
                               int'($urandom_range(0, ih + 12)) - 4);
    endcase
    void'(black_pixels_in(cmd, unloaded));
    if (unloaded) cmd.w = 0;
    return cmd;
  endfunction

  // start stays high between back-to-back beats
  task automatic send_cmd(input pixel_cmd_t cmd);
    bit unloaded;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= cmd.op;
    word_row <= cmd.row;
    word_column <= cmd.col;
    word_bits <= cmd.bits;
    rect_x <= cmd.x;
    rect_y <= cmd.y;
    rect_width <= cmd.w;
    rect_height <= cmd.h;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd.op == crbpc_pkg::OP_WRITE) begin
      image_words[cmd.row * WORDS_PER_ROW + cmd.col] = cmd.bits;
      word_loaded[cmd.row * WORDS_PER_ROW + cmd.col] = 1'b1;
    end else begin
      expected_black_counts.push_back(black_pixels_in(cmd, unloaded));
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_black_counts.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [crbpc_pkg::CFG_W-1:0] w,
                                input logic [crbpc_pkg::CFG_W-1:0] h);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= crbpc_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    image_width_reg = w;
    cfg_index <= crbpc_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    image_height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_image();
    logic [31:0] bits;
    for (int r = 0; r < eff_height(); r++) begin
      for (int c = 0; c < (eff_width() + 31) / 32; c++) begin
        case ($urandom_range(0, 7))
          0: bits = '0;
          1: bits = '1;
          default: bits = $urandom;
        endcase
        send_cmd(word_cmd(12'(r), 7'(c), bits));
      end
    end
  endtask

  task automatic random_traffic(input int n, input bit tail);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) idling_on = !tail && $urandom_range(0, 2) != 0;
      if (!tail && $urandom_range(0, 99) < 2) wait_idle();
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 3) != 0)
          send_cmd(word_cmd(12'($urandom_range(0, eff_height() - 1)),
                            7'($urandom_range(0, (eff_width() + 31) / 32 - 1)), $urandom));
        else
          send_cmd(word_cmd(12'($urandom), 7'($urandom), $urandom));
      end else begin
        send_cmd(random_count());
      end
    end
  endtask

  task automatic run_phase(input logic [crbpc_pkg::CFG_W-1:0] w,
                           input logic [crbpc_pkg::CFG_W-1:0] h,
                           input int n, input bit tail);
    idling_on = !tail;
    set_image_size(w, h);
    fill_image();
    random_traffic(n, tail);
  endtask

  // nothing loaded yet: every rectangle here clips to nothing
  task automatic test_empty_rects();
    idling_on = 1'b1;
    send_cmd(count_cmd(-8192, -8192, 8191, 8191));
    send_cmd(count_cmd(8191, 0, 8191, 1));
    send_cmd(count_cmd(0, 0, 0, 5));
    send_cmd(count_cmd(-100, 3, 100, -8192));
  endtask

  task automatic test_word_masks();
    send_cmd(word_cmd(0, 0, 32'hFFFF_FFFF));
    send_cmd(word_cmd(0, 1, 32'h0));
    send_cmd(word_cmd(1, 0, $urandom));
    send_cmd(word_cmd(1, 1, $urandom));
    send_cmd(word_cmd(4094, 126, $urandom));
    send_cmd(word_cmd(4094, 127, $urandom));
    send_cmd(word_cmd(4095, 126, $urandom));
    send_cmd(word_cmd(4095, 127, 32'hFFFF_FFFF));
    send_cmd(count_cmd(0, 0, 1, 1));
    send_cmd(count_cmd(3, 0, 20, 2));
    send_cmd(count_cmd(31, 1, 2, 1));
    send_cmd(count_cmd(-5, -3, 50, 5));
    send_cmd(count_cmd(4040, 4094, 8191, 8191));
  endtask

  task automatic test_register_extremes();
    set_image_size(0, 8191);
    send_cmd(count_cmd(0, 0, 10, 10));
    set_image_size(8191, 0);
    send_cmd(count_cmd(0, 0, 64, 2));
    set_image_size(8191, 8191);
    send_cmd(count_cmd(4040, 4094, 8191, 8191));
    send_cmd(count_cmd(0, 0, 64, 2));
    set_image_size(1, 1);
    send_cmd(count_cmd(-1, -1, 8191, 8191));
    set_image_size(4096, 4096);
    send_cmd(count_cmd(-8192, -8192, 8191 + 0, 8191));
    send_cmd(count_cmd(1, 0, 62, 2));
  endtask

  task automatic test_random_mix();
    run_phase(13'($urandom_range(1, 96)), 13'($urandom_range(1, 12)), 280, 1'b0);
    run_phase(13'($urandom_range(97, 224)), 13'($urandom_range(8, 24)), 280, 1'b0);
    run_phase(4096, 13'($urandom_range(1, 2)), 260, 1'b0);
  endtask

  task automatic test_quiet_tail();
    run_phase(13'($urandom_range(1, 160)), 13'($urandom_range(1, 16)), 280, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_black_counts.size() == 0) begin
        $display("%0t: black_count %0d with no count pending", $time, black_count);
        errors++;
      end else begin
        want_count = expected_black_counts.pop_front();
        if (black_count !== want_count) begin
          $display("%0t: black_count mismatch, expected %0d, actual %0d",
                   $time, want_count, black_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    stall_cycles = 0;
    idling_on = 1'b0;
    image_width_reg = crbpc_pkg::IMAGE_WIDTH_RESET;
    image_height_reg = crbpc_pkg::IMAGE_HEIGHT_RESET;
    rst <= 1'b1;
    start <= 1'b0;
    opcode <= crbpc_pkg::OP_WRITE;
    word_row <= '0;
    word_column <= '0;
    word_bits <= '0;
    rect_x <= '0;
    rect_y <= '0;
    rect_width <= '0;
    rect_height <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= crbpc_pkg::REG_IMAGE_WIDTH;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_rects();
    test_word_masks();
    test_register_extremes();
    test_random_mix();
    test_quiet_tail();
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
